FILE: src/pvwa_pkg.sv
// shared types and constants for the planar vram window access block
`default_nettype none
package pvwa_pkg;

  // default sizes
  localparam int DEF_PLANE_BYTES       = 32768;
  localparam int DEF_TEXT_BYTES        = 8192;
  localparam int DEF_PAGE_OFFSET_WORDS = 32768;
  localparam int DEF_VRAM_WORDS        = 65536;

  // window map
  localparam logic [15:0] TEXT_BASE = 16'h8000;
  localparam logic [15:0] ADDR_MASK = 16'hFF81;
  localparam logic [15:0] ADDR_PAGE = 16'hFF83;
  localparam logic [15:0] ADDR_R84  = 16'hFF84;
  localparam logic [15:0] ADDR_STAT = 16'hFF86;
  localparam logic [15:0] ADDR_FONT = 16'hFF94;
  localparam logic [15:0] ADDR_ANK  = 16'hFF99;

  // fixed read values
  localparam logic [7:0] RD_UNMAPPED = 8'hFF;
  localparam logic [7:0] RD_PAGE_ON  = 8'h10;
  localparam logic [7:0] RD_STAT     = 8'h10;
  localparam logic [7:0] RD_STAT_VS  = 8'h04;
  localparam logic [7:0] RD_STAT_HS  = 8'h80;
  localparam logic [7:0] RD_FONT     = 8'h80;

  localparam logic OP_READ  = 1'b0;
  localparam logic OP_WRITE = 1'b1;

  typedef enum logic [3:0] {
    K_PLANE,
    K_TEXT,
    K_MASK,
    K_PAGE,
    K_R84,
    K_STAT,
    K_FONT,
    K_ANK,
    K_NONE
  } kind_t;

  // one classified bus access
  typedef struct packed {
    kind_t       kind;
    logic        wr;
    logic [14:0] off;
    logic [7:0]  data;
    logic        vs;
    logic        hs;
  } cmd_t;

endpackage
`default_nettype wire

FILE: src/pvwa_ram.sv
// generic simple dual-port ram, read-first, registered read
`default_nettype none
module pvwa_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

FILE: src/pvwa_front.sv
// front end: accepts bus accesses and classifies them by window region
`default_nettype none
module pvwa_front #(
  parameter int PLANE_BYTES = pvwa_pkg::DEF_PLANE_BYTES,
  parameter int TEXT_BYTES  = pvwa_pkg::DEF_TEXT_BYTES
) (
  input  wire logic           in_tvalid,
  output logic                in_tready,
  input  wire logic [31:0]    in_tdata,
  input  wire logic           q_full,
  input  wire logic           busy,
  output logic                push,
  output pvwa_pkg::cmd_t      cmd
);
  import pvwa_pkg::*;

  logic        wr;
  logic [15:0] addr;

  assign wr   = in_tdata[0];
  assign addr = in_tdata[16:1];

  assign in_tready = !q_full && !busy;
  assign push      = in_tvalid && in_tready;

  always_comb begin
    cmd.wr   = wr;
    cmd.off  = addr[14:0];
    cmd.data = in_tdata[24:17];
    cmd.vs   = in_tdata[25];
    cmd.hs   = in_tdata[26];
    priority if ({1'b0, addr} < 17'(PLANE_BYTES)) begin
      cmd.kind = K_PLANE;
    end else if (addr[15] && ({2'b00, addr[14:0]} < 17'(TEXT_BYTES))) begin
      cmd.kind = K_TEXT;
    end else if (addr == ADDR_MASK) begin
      cmd.kind = K_MASK;
    end else if (addr == ADDR_PAGE) begin
      cmd.kind = K_PAGE;
    end else if (addr == ADDR_R84) begin
      cmd.kind = K_R84;
    end else if (addr == ADDR_STAT) begin
      cmd.kind = K_STAT;
    end else if (addr == ADDR_FONT) begin
      cmd.kind = K_FONT;
    end else if (addr == ADDR_ANK) begin
      cmd.kind = K_ANK;
    end else begin
      cmd.kind = K_NONE;
    end
  end

endmodule
`default_nettype wire

FILE: src/pvwa_queue.sv
// two-entry queue of classified accesses between front and back end
`default_nettype none
module pvwa_queue (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           push,
  input  wire pvwa_pkg::cmd_t push_cmd,
  input  wire logic           pop,
  output logic                full,
  output logic                head_vld,
  output pvwa_pkg::cmd_t      head_cmd
);
  import pvwa_pkg::*;

  cmd_t       ent_r [2];
  logic       wptr_r;
  logic       rptr_r;
  logic [1:0] cnt_r;
  logic [1:0] cnt_nxt;

  assign full     = (cnt_r == 2'd2);
  assign head_vld = (cnt_r != 2'd0);
  assign head_cmd = ent_r[rptr_r];

  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + 2'd1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= 1'b0;
      rptr_r <= 1'b0;
      cnt_r  <= 2'd0;
    end else begin
      cnt_r <= cnt_nxt;
      if (push) begin
        wptr_r <= !wptr_r;
      end
      if (pop) begin
        rptr_r <= !rptr_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      ent_r[wptr_r] <= push_cmd;
    end
  end

endmodule
`default_nettype wire

FILE: src/pvwa_back.sv
// back end: vram and text ram access, window registers, result register
`default_nettype none
module pvwa_back #(
  parameter int TEXT_BYTES        = pvwa_pkg::DEF_TEXT_BYTES,
  parameter int PAGE_OFFSET_WORDS = pvwa_pkg::DEF_PAGE_OFFSET_WORDS,
  parameter int VRAM_WORDS        = pvwa_pkg::DEF_VRAM_WORDS
) (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           q_vld,
  input  wire pvwa_pkg::cmd_t q_cmd,
  output logic                q_pop,
  output logic                busy,
  output logic                out_tvalid,
  input  wire logic           out_tready,
  output logic [15:0]         out_tdata
);
  import pvwa_pkg::*;

  localparam int VAW       = $clog2(VRAM_WORDS);
  localparam int TAW       = $clog2(TEXT_BYTES);
  localparam int CLR_DEPTH = (VRAM_WORDS > TEXT_BYTES) ? VRAM_WORDS : TEXT_BYTES;
  localparam int CW        = $clog2(CLR_DEPTH + 1);
  localparam logic [14:0] TEXT_HALF = 15'(TEXT_BYTES / 2);

  // window registers
  logic [7:0] mask_r;
  logic       page_r;
  logic       ank_r;

  // clearing pass
  logic [CW-1:0] clr_r;

  // execute stage: ram read data for this item is in the ram output register
  logic           x_vld_r;
  cmd_t           x_cmd_r;
  logic [VAW-1:0] x_idx_r;
  logic           x_vfwd_r;
  logic           x_tfwd_r;
  logic [31:0]    fwd_word_r;
  logic [7:0]     fwd_byte_r;

  logic           out_vld_r;
  logic [7:0]     out_rd_r;
  logic           out_tw_r;

  logic           x_done;
  logic           page_eff;
  logic [18:0]    sum;
  logic [VAW-1:0] pop_idx;
  logic [31:0]    vram_rdata;
  logic [7:0]     text_rdata;
  logic [31:0]    word_cur;
  logic [7:0]     byte_cur;
  logic [31:0]    word_new;
  logic [7:0]     rd;
  logic           tw;
  logic           x_vwr;
  logic           x_twr;
  logic           v_haz;
  logic           t_haz;
  logic [1:0]     sel;
  logic [3:0]     ml;
  logic [7:0]     b;

  logic           vram_we;
  logic [VAW-1:0] vram_waddr;
  logic [31:0]    vram_wdata;
  logic           text_we;
  logic [TAW-1:0] text_waddr;
  logic [7:0]     text_wdata;

  assign busy   = (clr_r < CW'(CLR_DEPTH));
  assign x_done = x_vld_r && (!out_vld_r || out_tready);
  assign q_pop  = q_vld && !busy && (!x_vld_r || x_done);

  // page select as it stands once the item ahead has retired
  assign page_eff = (x_done && x_cmd_r.wr && (x_cmd_r.kind == K_PAGE)) ?
                    x_cmd_r.data[4] : page_r;

  // word index modulo vram size, sum stays below eight times the size
  always_comb begin
    sum = 19'(q_cmd.off) + (page_eff ? 19'(PAGE_OFFSET_WORDS) : 19'd0);
    for (int k = 2; k >= 0; k--) begin
      if (sum >= (19'(VRAM_WORDS) << k)) begin
        sum = sum - (19'(VRAM_WORDS) << k);
      end
    end
    pop_idx = sum[VAW-1:0];
  end

  assign word_cur = x_vfwd_r ? fwd_word_r : vram_rdata;
  assign byte_cur = x_tfwd_r ? fwd_byte_r : text_rdata;
  assign sel      = mask_r[7:6];
  assign ml       = mask_r[3:0];

  always_comb begin
    word_new = word_cur;
    for (int i = 0; i < 4; i++) begin
      b = word_cur[8*i +: 8] & ~{ml, ml};
      if (x_cmd_r.data[6-2*i]) begin
        b = b | {ml, 4'b0000};
      end
      if (x_cmd_r.data[7-2*i]) begin
        b = b | {4'b0000, ml};
      end
      word_new[8*i +: 8] = b;
    end
  end

  always_comb begin
    rd = RD_UNMAPPED;
    tw = 1'b0;
    if (x_cmd_r.wr) begin
      rd = 8'h00;
      tw = (x_cmd_r.kind == K_TEXT);
    end else begin
      unique case (x_cmd_r.kind)
        K_PLANE: begin
          rd = 8'h00;
          for (int i = 0; i < 4; i++) begin
            rd[6-2*i] = word_cur[8*i + 4 + 32'(sel)];
            rd[7-2*i] = word_cur[8*i + 32'(sel)];
          end
        end
        K_TEXT: begin
          // font mode hides the upper half of text ram on reads
          if (!(ank_r && (x_cmd_r.off >= TEXT_HALF))) begin
            rd = byte_cur;
          end
        end
        K_MASK:  rd = mask_r;
        K_PAGE:  rd = page_r ? RD_PAGE_ON : 8'h00;
        K_R84:   rd = 8'h00;
        K_STAT:  rd = RD_STAT | (x_cmd_r.vs ? RD_STAT_VS : 8'h00) |
                      (x_cmd_r.hs ? RD_STAT_HS : 8'h00);
        K_FONT:  rd = RD_FONT;
        K_ANK:   rd = RD_UNMAPPED;
        K_NONE:  rd = RD_UNMAPPED;
        default: rd = RD_UNMAPPED;
      endcase
    end
  end

  assign x_vwr = x_done && x_cmd_r.wr && (x_cmd_r.kind == K_PLANE);
  assign x_twr = x_done && x_cmd_r.wr && (x_cmd_r.kind == K_TEXT);

  // read issued in the same cycle as a write to the same entry sees old data
  assign v_haz = x_vwr && (q_cmd.kind == K_PLANE) && (x_idx_r == pop_idx);
  assign t_haz = x_twr && (q_cmd.kind == K_TEXT) &&
                 (x_cmd_r.off[TAW-1:0] == q_cmd.off[TAW-1:0]);

  always_comb begin
    if (busy) begin
      vram_we    = (clr_r < CW'(VRAM_WORDS));
      vram_waddr = clr_r[VAW-1:0];
      vram_wdata = 32'h0;
      text_we    = (clr_r < CW'(TEXT_BYTES));
      text_waddr = clr_r[TAW-1:0];
      text_wdata = 8'h00;
    end else begin
      vram_we    = x_vwr;
      vram_waddr = x_idx_r;
      vram_wdata = word_new;
      text_we    = x_twr;
      text_waddr = x_cmd_r.off[TAW-1:0];
      text_wdata = x_cmd_r.data;
    end
  end

  pvwa_ram #(
    .WIDTH (32),
    .DEPTH (VRAM_WORDS)
  ) u_vram (
    .clk   (clk),
    .we    (vram_we),
    .waddr (vram_waddr),
    .wdata (vram_wdata),
    .re    (q_pop && (q_cmd.kind == K_PLANE)),
    .raddr (pop_idx),
    .rdata (vram_rdata)
  );

  pvwa_ram #(
    .WIDTH (8),
    .DEPTH (TEXT_BYTES)
  ) u_text (
    .clk   (clk),
    .we    (text_we),
    .waddr (text_waddr),
    .wdata (text_wdata),
    .re    (q_pop && (q_cmd.kind == K_TEXT)),
    .raddr (q_cmd.off[TAW-1:0]),
    .rdata (text_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mask_r    <= 8'h00;
      page_r    <= 1'b0;
      ank_r     <= 1'b0;
      clr_r     <= '0;
      x_vld_r   <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      if (busy) begin
        clr_r <= clr_r + CW'(1);
      end
      if (x_done && x_cmd_r.wr) begin
        if (x_cmd_r.kind == K_MASK) begin
          mask_r <= x_cmd_r.data;
        end
        if (x_cmd_r.kind == K_PAGE) begin
          page_r <= x_cmd_r.data[4];
        end
        if (x_cmd_r.kind == K_ANK) begin
          ank_r <= x_cmd_r.data[0];
        end
      end
      if (q_pop) begin
        x_vld_r <= 1'b1;
      end else if (x_done) begin
        x_vld_r <= 1'b0;
      end
      if (x_done) begin
        out_vld_r <= 1'b1;
      end else if (out_tready) begin
        out_vld_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      x_cmd_r    <= q_cmd;
      x_idx_r    <= pop_idx;
      x_vfwd_r   <= v_haz;
      x_tfwd_r   <= t_haz;
      fwd_word_r <= word_new;
      fwd_byte_r <= x_cmd_r.data;
    end
    if (x_done) begin
      out_rd_r <= rd;
      out_tw_r <= tw;
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = {7'b0000000, out_tw_r, out_rd_r};

endmodule
`default_nettype wire

FILE: src/planar_vram_window_access.sv
// Byte bus port onto a 64 KiB window over planar VRAM, text RAM and a few registers.
//
// Input channel in_*: one bus access per item (read or write, offset, write byte,
// current vsync/hsync levels). Result channel out_*: exactly one item per access,
// in order, carrying the read byte (0xFF where unmapped, 0 on writes) and a flag
// that a write landed in text RAM.
// An accepted item is classified and queued, then issues its RAM read, then
// completes against the RAM output and lands in the result register, which
// drives out_tvalid.
// Throughput is one item per clock while out_tready is high, set by the single
// VRAM port pair: a plane write is a read-modify-write of one 32-bit word, and a
// back-to-back access to the same word takes the freshly merged word through a
// forwarding register. After reset both RAMs are cleared one entry per clock;
// in_tready stays low until the clearing pass has covered the larger RAM.
// When the receiver holds out_tready low the result register holds, the item
// in flight waits, the two-entry queue fills and in_tready then drops.
`default_nettype none
module planar_vram_window_access #(
  parameter int PLANE_BYTES       = pvwa_pkg::DEF_PLANE_BYTES,
  parameter int TEXT_BYTES        = pvwa_pkg::DEF_TEXT_BYTES,
  parameter int PAGE_OFFSET_WORDS = pvwa_pkg::DEF_PAGE_OFFSET_WORDS,
  parameter int VRAM_WORDS        = pvwa_pkg::DEF_VRAM_WORDS
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  // opcode[0], address[16:1], write_data[24:17], vsync[25], hsync[26], zero above
  input  wire logic [31:0] in_tdata,
  output logic             out_tvalid,
  input  wire logic        out_tready,
  // read_data[7:0], text_written[8], zero above
  output logic [15:0]      out_tdata
);
  import pvwa_pkg::*;

  logic q_full;
  logic busy;
  logic push;
  cmd_t push_cmd;
  logic q_pop;
  logic q_vld;
  cmd_t q_cmd;

  pvwa_front #(
    .PLANE_BYTES (PLANE_BYTES),
    .TEXT_BYTES  (TEXT_BYTES)
  ) u_front (
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .q_full    (q_full),
    .busy      (busy),
    .push      (push),
    .cmd       (push_cmd)
  );

  pvwa_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_cmd (push_cmd),
    .pop      (q_pop),
    .full     (q_full),
    .head_vld (q_vld),
    .head_cmd (q_cmd)
  );

  pvwa_back #(
    .TEXT_BYTES        (TEXT_BYTES),
    .PAGE_OFFSET_WORDS (PAGE_OFFSET_WORDS),
    .VRAM_WORDS        (VRAM_WORDS)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_vld      (q_vld),
    .q_cmd      (q_cmd),
    .q_pop      (q_pop),
    .busy       (busy),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule
`default_nettype wire

FILE: src/pvwa_checker.sv
// port-level checks for the planar vram window access block, with its bind
`default_nettype none
module pvwa_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_tvalid,
  input wire logic        in_tready,
  input wire logic [31:0] in_tdata,
  input wire logic        out_tvalid,
  input wire logic        out_tready,
  input wire logic [15:0] out_tdata
);

  // a stalled result stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("result dropped while stalled");

  // a text write reports a zero read byte
  a_tw_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[8] |-> (out_tdata[7:0] == 8'h00))
    else $error("text write flag with nonzero read byte");

  // memory clearing keeps the input closed right after reset
  a_rst_closed: assert property (@(posedge clk)
    !rst_n |=> !in_tready)
    else $error("input open during clearing");

  // no result appears out of reset
  a_rst_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result after reset");

  // a waiting input item stays offered and unchanged
  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && !in_tready |=> in_tvalid && $stable(in_tdata))
    else $error("input item changed while waiting");

endmodule

bind planar_vram_window_access pvwa_checker u_pvwa_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .in_tdata   (in_tdata),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);
`default_nettype wire
